@@ design/bitmap_text_rasterizer_unit_defines.svh @@
// Assertion macros shared by the rasterizer modules.
// No dependencies; modules include this before their assertions.
`ifndef BITMAP_TEXT_RASTERIZER_UNIT_DEFINES_SVH
`define BITMAP_TEXT_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define BTR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define BTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/btr_pkg.sv @@
// Shared types, constants and the 5x7 font table of the text rasterizer.
// No dependencies.
package btr_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;
  localparam int DEF_MAX_SCALE     = 8;

  localparam int COORD_W    = 12;
  localparam int CUR_X_W    = 11;
  localparam int CUR_Y_W    = 10;
  localparam int CUR_X_MAX  = 1023;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_DRAW_POS = 2'd1,
    OP_DRAW_CUR = 2'd2,
    OP_READ     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic lookup;
    logic pix_read;
    logic pix_write;
    logic pix_next;
    logic finish;
  } btr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scale_zero;
    logic pix_plot;
    logic pix_last;
  } btr_status_t;

  typedef struct packed {
    logic                  found;
    logic [GLYPH_BITS-1:0] bits;
  } glyph_t;

  function automatic logic [GLYPH_BITS-1:0] g5(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3,
                                               input logic [7:0] c4);
    return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
  endfunction

  // Bit c*7+r of bits is column c, row r. Unknown codes come back blank.
  function automatic glyph_t font_lookup(input logic [7:0] code);
    glyph_t g;
    g.found = 1'b1;
    case (code)
      8'h20: g.bits = g5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h30: g.bits = g5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      8'h31: g.bits = g5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      8'h32: g.bits = g5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      8'h33: g.bits = g5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      8'h34: g.bits = g5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      8'h35: g.bits = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      8'h36: g.bits = g5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      8'h37: g.bits = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      8'h38: g.bits = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h39: g.bits = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      8'h2E: g.bits = g5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      8'h2D: g.bits = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      8'h3A: g.bits = g5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      8'h25: g.bits = g5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      8'h7E: g.bits = g5(8'h07, 8'h05, 8'h07, 8'h00, 8'h00);
      8'h41: g.bits = g5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      8'h42: g.bits = g5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      8'h43: g.bits = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      8'h44: g.bits = g5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      8'h45: g.bits = g5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      8'h46: g.bits = g5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      8'h48: g.bits = g5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      8'h49: g.bits = g5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      8'h4C: g.bits = g5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      8'h4D: g.bits = g5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      8'h4E: g.bits = g5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      8'h4F: g.bits = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      8'h50: g.bits = g5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      8'h51: g.bits = g5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      8'h52: g.bits = g5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      8'h53: g.bits = g5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      8'h54: g.bits = g5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      8'h55: g.bits = g5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      default: begin
        g.found = 1'b0;
        g.bits  = '0;
      end
    endcase
    return g;
  endfunction

endpackage

@@ design/btr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/btr_ctrl.sv @@
// Controller state machine of the text rasterizer.
// Depends on btr_pkg and the assertion macros header.
`include "bitmap_text_rasterizer_unit_defines.svh"
module btr_ctrl
  import btr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_opcode,
  input  btr_status_t st,
  output btr_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_CLR  = 9'b000000100,
    S_LOOK = 9'b000001000,
    S_PIX  = 9'b000010000,
    S_WR   = 9'b000100000,
    S_DONE = 9'b001000000,
    S_RD   = 9'b010000000,
    S_RDW  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (opcode_t'(in_opcode))
            OP_CLEAR:    state_nxt = S_CLR;
            OP_DRAW_POS: state_nxt = S_LOOK;
            OP_DRAW_CUR: state_nxt = S_LOOK;
            OP_READ:     state_nxt = S_RD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = st.scale_zero ? S_DONE : S_PIX;
      end
      S_PIX: begin
        if (st.pix_plot) begin
          // fetch the word, merge the bit next cycle
          cmd.pix_read = 1'b1;
          state_nxt    = S_WR;
        end else begin
          cmd.pix_next = 1'b1;
          if (st.pix_last) state_nxt = S_DONE;
        end
      end
      S_WR: begin
        cmd.pix_write = 1'b1;
        cmd.pix_next  = 1'b1;
        state_nxt     = st.pix_last ? S_DONE : S_PIX;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `BTR_ASSERT_NEXT(a_start_leaves_idle, start && !busy, state_r != S_IDLE, "accepted word did not start")
  `BTR_ASSERT_NEXT(a_done_to_idle, state_r == S_DONE, state_r == S_IDLE, "draw did not return to idle")
  `BTR_ASSERT_NEXT(a_read_then_write, cmd.pix_read, cmd.pix_write, "pixel read without merge write")

endmodule

@@ design/btr_datapath.sv @@
// Datapath of the text rasterizer: cursor, glyph walk counters, frame RAM, result.
// Depends on btr_pkg and btr_ram.
module btr_datapath
  import btr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int MAX_SCALE     = DEF_MAX_SCALE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  btr_cmd_t          cmd,
  output btr_status_t       st,
  input  logic [1:0]        in_opcode,
  input  logic signed [9:0] in_x_position,
  input  logic signed [9:0] in_y_position,
  input  logic [7:0]        in_char_code,
  input  logic [3:0]        in_scale,
  input  logic [2:0]        in_read_page,
  input  logic [6:0]        in_read_column,
  output logic              out_valid,
  output logic [7:0]        out_read_data,
  output logic              out_glyph_found
);

  localparam int NUM_PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH     = NUM_PAGES * SCREEN_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int CIW       = $clog2(GLYPH_BITS);

  logic signed [CUR_X_W-1:0] cur_x_r, cur_x_nxt;
  logic signed [CUR_Y_W-1:0] cur_y_r, cur_y_nxt;
  logic [3:0]                cur_s_r, cur_s_nxt;

  logic [1:0]                op_r;
  logic [7:0]                code_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, bx_r, by_r;
  logic [3:0]                s_r;
  logic [AW-1:0]             rd_addr_r;
  logic                      rd_ok_r;
  glyph_t                    glyph_r;
  logic [2:0]                col_r, row_r;
  logic [3:0]                dx_r, dy_r;
  logic [AW-1:0]             clr_r;
  logic [AW-1:0]             pix_addr_r;
  logic [7:0]                pix_mask_r;

  // load-time scale and cursor math
  logic [3:0]                s_cl, s_ld;
  logic signed [COORD_W-1:0] x_ld, y_ld, adv, x_sum, x_sat;

  always_comb begin
    s_cl = (in_scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : in_scale;
    if (in_opcode == OP_DRAW_POS) begin
      x_ld = COORD_W'(in_x_position);
      y_ld = COORD_W'(in_y_position);
      s_ld = s_cl;
    end else begin
      x_ld = COORD_W'(cur_x_r);
      y_ld = COORD_W'(cur_y_r);
      s_ld = cur_s_r;
    end
    adv   = $signed({{(COORD_W-6){1'b0}}, s_ld, 2'b00}) +
            $signed({{(COORD_W-5){1'b0}}, s_ld, 1'b0});
    x_sum = x_ld + adv;
    x_sat = (x_sum > COORD_W'(CUR_X_MAX)) ? COORD_W'(CUR_X_MAX) : x_sum;
  end

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    cur_s_nxt = cur_s_r;
    if (cmd.load && in_opcode == OP_DRAW_POS) begin
      cur_x_nxt = x_sat[CUR_X_W-1:0];
      cur_y_nxt = in_y_position;
      cur_s_nxt = s_cl;
    end else if (cmd.load && in_opcode == OP_DRAW_CUR) begin
      cur_x_nxt = x_sat[CUR_X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      cur_s_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      cur_s_r <= cur_s_nxt;
    end
  end

  // current pixel
  logic signed [COORD_W-1:0] px, py;
  logic                      on_screen, gbit;
  logic [CIW-1:0]            gidx;
  logic [3:0]                s_m1;
  logic                      dy_end, dx_end, sq_end;

  always_comb begin
    px        = bx_r + $signed({{(COORD_W-4){1'b0}}, dx_r});
    py        = by_r + $signed({{(COORD_W-4){1'b0}}, dy_r});
    on_screen = !px[COORD_W-1] && (px < COORD_W'(SCREEN_WIDTH)) &&
                !py[COORD_W-1] && (py < COORD_W'(SCREEN_HEIGHT));
    gidx      = CIW'(col_r) * CIW'(GLYPH_ROWS) + CIW'(row_r);
    gbit      = glyph_r.bits[gidx];
    s_m1      = s_r - 4'd1;
    dy_end    = (dy_r == s_m1);
    dx_end    = (dx_r == s_m1);
    sq_end    = !gbit || (dx_end && dy_end);
  end

  assign st.clr_last   = (clr_r == AW'(DEPTH - 1));
  assign st.scale_zero = (s_r == 4'd0);
  assign st.pix_plot   = gbit && on_screen;
  assign st.pix_last   = sq_end && (col_r == 3'(GLYPH_COLS - 1)) &&
                         (row_r == 3'(GLYPH_ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.load) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      code_r    <= in_char_code;
      x0_r      <= x_ld;
      y0_r      <= y_ld;
      s_r       <= s_ld;
      rd_ok_r   <= (32'(in_read_page) < NUM_PAGES) && (32'(in_read_column) < SCREEN_WIDTH);
      rd_addr_r <= AW'(32'(in_read_page) * SCREEN_WIDTH + 32'(in_read_column));
    end
    if (cmd.lookup) begin
      glyph_r <= font_lookup(code_r);
      bx_r    <= x0_r;
      by_r    <= y0_r;
      col_r   <= '0;
      row_r   <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
    end else if (cmd.pix_next) begin
      if (gbit && !dy_end) begin
        dy_r <= dy_r + 4'd1;
      end else if (gbit && !dx_end) begin
        dx_r <= dx_r + 4'd1;
        dy_r <= '0;
      end else begin
        dx_r <= '0;
        dy_r <= '0;
        if (row_r != 3'(GLYPH_ROWS - 1)) begin
          row_r <= row_r + 3'd1;
          by_r  <= by_r + COORD_W'(s_r);
        end else begin
          row_r <= '0;
          col_r <= col_r + 3'd1;
          by_r  <= y0_r;
          bx_r  <= bx_r + COORD_W'(s_r);
        end
      end
    end
    if (cmd.pix_read) begin
      pix_addr_r <= AW'(32'(py[COORD_W-1:3]) * SCREEN_WIDTH + 32'(px));
      pix_mask_r <= 8'd1 << py[2:0];
    end
  end

  // frame RAM: clear sweep or pixel merge on the write side
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = cmd.clr_step || cmd.pix_write;
    ram_waddr = cmd.clr_step ? clr_r : pix_addr_r;
    ram_wdata = cmd.clr_step ? 8'h00 : (ram_rdata | pix_mask_r);
    ram_raddr = cmd.pix_read ? AW'(32'(py[COORD_W-1:3]) * SCREEN_WIDTH + 32'(px)) : rd_addr_r;
  end

  btr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_read_data   <= (op_r == OP_READ && rd_ok_r) ? ram_rdata : 8'h00;
      out_glyph_found <= (op_r == OP_DRAW_POS || op_r == OP_DRAW_CUR) && glyph_r.found;
    end
  end

endmodule

@@ design/bitmap_text_rasterizer_unit.sv @@
// Scaled 5x7 text rasterizer over a page-organized monochrome frame RAM.
// Depends on btr_pkg, btr_ctrl, btr_datapath (which holds btr_ram).
//
// One command at a time: start is taken while busy is low, and the single
// result word appears on out_* with out_valid high for one cycle; the
// receiver cannot stall it. Busy time comes from the frame RAM walk: after
// reset a clearing pass over all pages*width words (1024 at 128x64) runs
// before busy drops. After an accepted word busy stays high while a clear
// sweeps every word, and through S_RD and S_RDW on read. A draw holds busy
// through lookup and finish, plus an S_PIX step per clear glyph pixel,
// scale*scale S_PIX steps per set glyph pixel and an S_WR step for each
// on-screen plotted pixel (read-modify-write). out_valid is high in the first
// cycle with busy low, so the next word can be taken at the edge that ends
// the result cycle.
module bitmap_text_rasterizer_unit
  import btr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int MAX_SCALE     = DEF_MAX_SCALE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic signed [9:0] in_x_position,
  input  logic signed [9:0] in_y_position,
  input  logic [7:0]        in_char_code,
  input  logic [3:0]        in_scale,
  input  logic [2:0]        in_read_page,
  input  logic [6:0]        in_read_column,
  output logic              out_valid,
  output logic [7:0]        out_read_data,
  output logic              out_glyph_found
);

  btr_cmd_t    cmd;
  btr_status_t st;

  btr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_opcode(in_opcode),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  btr_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .MAX_SCALE    (MAX_SCALE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_opcode      (in_opcode),
    .in_x_position  (in_x_position),
    .in_y_position  (in_y_position),
    .in_char_code   (in_char_code),
    .in_scale       (in_scale),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_glyph_found(out_glyph_found)
  );

endmodule

@@ tb/bitmap_text_rasterizer_unit_tb.sv @@
// Testbench for bitmap_text_rasterizer_unit: drives draw, clear and read words,
// predicts each result with a local framebuffer model and checks it.
// Depends on btr_pkg and the rasterizer RTL.
`timescale 1ns / 100ps

module bitmap_text_rasterizer_unit_tb
  import btr_pkg::*;
();

  localparam int SCR_W = 128;
  localparam int SCR_H = 64;
  localparam int SCALE_LIMIT = 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [7:0] read_data;
    logic       glyph_found;
  } pixel_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic signed [9:0] in_x_position;
  logic signed [9:0] in_y_position;
  logic [7:0]        in_char_code;
  logic [3:0]        in_scale;
  logic [2:0]        in_read_page;
  logic [6:0]        in_read_column;
  logic              out_valid;
  logic [7:0]        out_read_data;
  logic              out_glyph_found;

  bitmap_text_rasterizer_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_x_position(in_x_position),
    .in_y_position(in_y_position), .in_char_code(in_char_code),
    .in_scale(in_scale), .in_read_page(in_read_page),
    .in_read_column(in_read_column), .out_valid(out_valid),
    .out_read_data(out_read_data), .out_glyph_found(out_glyph_found)
  );

  logic [7:0]    shadow_fb [0:(SCR_H/8)*SCR_W-1];
  int            pen_x, pen_y, pen_scale;
  pixel_result_t pending_results[$];
  int            mismatch_count;
  int            idle_cycles;
  int            gap_pct;

  // 5x7 column font, independent copy: code and five column bytes.
  logic [7:0] glyph_codes [0:33] = '{8'h20, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
    8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h2D, 8'h3A, 8'h25, 8'h7E, 8'h41, 8'h42, 8'h43,
    8'h44, 8'h45, 8'h46, 8'h48, 8'h49, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55};
  logic [39:0] glyph_art [0:33] = '{
    40'h0000000000, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946,
    40'h2141454B31, 40'h1814127F10, 40'h2745454539, 40'h3C4A494930,
    40'h0171090503, 40'h3649494936, 40'h064949291E, 40'h0060600000,
    40'h0808080808, 40'h0036360000, 40'h2313086462, 40'h0705070000,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h7F0808087F, 40'h00417F4100,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F};

  function automatic bit raster_glyph(int x0, int y0, logic [7:0] code, int s);
    int idx;
    logic [7:0] col_byte;
    int px, py;
    idx = -1;
    for (int i = 0; i < 34; i++) if (idx < 0 && glyph_codes[i] == code) idx = i;
    if (idx < 0) return 1'b0;
    for (int c = 0; c < 5; c++) begin
      col_byte = glyph_art[idx][39-8*c -: 8];
      for (int r = 0; r < 7; r++) begin
        if (col_byte[r]) begin
          for (int dx = 0; dx < s; dx++) begin
            for (int dy = 0; dy < s; dy++) begin
              px = x0 + c*s + dx;
              py = y0 + r*s + dy;
              if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H)
                shadow_fb[(py/8)*SCR_W + px][py%8] = 1'b1;
            end
          end
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic pixel_result_t predict_word(opcode_t op, int x, int y,
                                                 logic [7:0] code, int s,
                                                 int page, int col);
    pixel_result_t res;
    res.read_data = '0;
    res.glyph_found = 1'b0;
    case (op)
      OP_CLEAR: begin
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
      end
      OP_DRAW_POS: begin
        if (s > SCALE_LIMIT) s = SCALE_LIMIT;
        res.glyph_found = raster_glyph(x, y, code, s);
        pen_x = x + 6*s;
        if (pen_x > CUR_X_MAX) pen_x = CUR_X_MAX;
        pen_y = y;
        pen_scale = s;
      end
      OP_DRAW_CUR: begin
        res.glyph_found = raster_glyph(pen_x, pen_y, code, pen_scale);
        pen_x = pen_x + 6*pen_scale;
        if (pen_x > CUR_X_MAX) pen_x = CUR_X_MAX;
      end
      default: begin
        res.read_data = shadow_fb[page*SCR_W + col];
      end
    endcase
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Send one word; raises start and holds it until busy reads low, then drops it.
  task automatic send_word(opcode_t op, logic signed [9:0] x, logic signed [9:0] y,
                           logic [7:0] code, logic [3:0] s, logic [2:0] page,
                           logic [6:0] col);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start          <= 1'b1;
    in_opcode      <= op;
    in_x_position  <= x;
    in_y_position  <= y;
    in_char_code   <= code;
    in_scale       <= s;
    in_read_page   <= page;
    in_read_column <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_word(op, int'(x), int'(y), code, int'(s),
                                           int'(page), int'(col)));
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    pixel_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word");
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.read_data !== out_read_data ||
            exp_res.glyph_found !== out_glyph_found) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("data exp %h got %h, found exp %b got %b", exp_res.read_data,
                     out_read_data, exp_res.glyph_found, out_glyph_found);
        end
      end
    end
  end

  // Watchdog: counts cycles with neither an accepted word nor a result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [7:0] pick_code();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      default: return glyph_codes[$urandom_range(33)];
    endcase
  endfunction

  function automatic logic [3:0] pick_scale();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 4'd1;
    if (r < 80) return 4'd2;
    if (r < 90) return 4'($urandom_range(3, 4));
    if (r < 95) return 4'd0;
    return 4'($urandom_range(5, 15));
  endfunction

  task automatic read_random();
    send_word(OP_READ, 10'($urandom), 10'($urandom), 8'($urandom), 4'($urandom),
              3'($urandom_range(7)), 7'($urandom_range(127)));
  endtask

  task automatic test_directed();
    send_word(OP_READ, '0, '0, '0, '0, '0, '0);
    send_word(OP_DRAW_CUR, '0, '0, 8'h41, '0, '0, '0);
    send_word(OP_DRAW_POS, '0, '0, 8'h30, 4'd1, '0, '0);
    for (int c = 0; c < 6; c++) send_word(OP_READ, '0, '0, '0, '0, '0, 7'(c));
    send_word(OP_DRAW_CUR, -10'sd1, -10'sd1, 8'h7E, 4'hF, 3'd7, 7'd127);
    send_word(OP_DRAW_POS, -10'sd512, -10'sd512, 8'h25, 4'd8, '0, '0);
    send_word(OP_DRAW_POS, 10'sd120, 10'sd58, 8'h4D, 4'hF, '0, '0);
    send_word(OP_READ, '0, '0, '0, '0, 3'd7, 7'd127);
    send_word(OP_DRAW_POS, 10'sd511, 10'sd511, 8'hFF, 4'd8, '0, '0);
    send_word(OP_DRAW_CUR, '0, '0, 8'h00, '0, '0, '0);
    send_word(OP_DRAW_POS, 10'sd500, 10'sd3, 8'h20, 4'd3, '0, '0);
    send_word(OP_DRAW_POS, -10'sd3, -10'sd3, 8'h38, 4'd2, '0, '0);
    send_word(OP_READ, '0, '0, '0, '0, '0, '0);
    send_word(OP_CLEAR, -10'sd1, -10'sd1, 8'hFF, 4'hF, 3'd7, 7'd127);
    send_word(OP_READ, '0, '0, '0, '0, '0, '0);
    send_word(OP_DRAW_POS, 10'sd5, 10'sd4, 8'h55, 4'd0, '0, '0);
    send_word(OP_DRAW_CUR, '0, '0, 8'h55, '0, '0, '0);
  endtask

  // Text lines: draw, draws at the pen, reads of one page, maybe one more word.
  task automatic test_text_lines(int n_lines);
    int row;
    for (int l = 0; l < n_lines; l++) begin
      send_word(OP_DRAW_POS, 10'($urandom_range(0, 60)) - 10'sd8,
                10'($urandom_range(0, 70)) - 10'sd8, pick_code(), pick_scale(),
                3'($urandom), 7'($urandom));
      for (int k = $urandom_range(2, 6); k > 0; k--)
        send_word(OP_DRAW_CUR, 10'($urandom), 10'($urandom), pick_code(),
                  4'($urandom), 3'($urandom), 7'($urandom));
      row = $urandom_range(7);
      for (int k = $urandom_range(4, 10); k > 0; k--)
        send_word(OP_READ, 10'($urandom), 10'($urandom), 8'($urandom), 4'($urandom),
                  3'(row), 7'($urandom_range(0, 90)));
      case ($urandom_range(9))
        0: send_word(OP_CLEAR, 10'($urandom), 10'($urandom), 8'($urandom),
                     4'($urandom), 3'($urandom), 7'($urandom));
        1: send_word(OP_DRAW_POS, 10'($urandom), 10'($urandom), 8'($urandom),
                     4'($urandom_range(1, 2)), 3'($urandom), 7'($urandom));
        2: read_random();
        default: ;
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_CLEAR;
    in_x_position = '0;
    in_y_position = '0;
    in_char_code = '0;
    in_scale = '0;
    in_read_page = '0;
    in_read_column = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    gap_pct = 0;
    pen_x = 0;
    pen_y = 0;
    pen_scale = 0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    gap_pct = 22;
    test_text_lines(22);
    gap_pct = 81;
    test_text_lines(22);
    gap_pct = 0;
    test_text_lines(23);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
